// ===== rtl/usf_pkg.sv =====
// Shared types and constants for the UTF-8 sequence filter.
package usf_pkg;

   // Input item kinds carried on the request tuser bit.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_RESYNC = 1'b1;

   // Held sequence storage: lead byte plus up to three continuation bytes.
   localparam int SEQ_DEPTH = 4;
   localparam int SEQ_IDX_W = $clog2(SEQ_DEPTH);
   localparam int SEQ_CNT_W = SEQ_IDX_W + 1;

   // Byte classes.
   localparam logic [7:0] ASCII_MIN = 8'h00;
   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] LEAD2_MIN = 8'hC0;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;
   localparam logic [7:0] LEAD4_MAX = 8'hF7;
   localparam logic [1:0] CONT_TAG  = 2'b10;

   // Controller states.
   typedef enum logic [1:0] {
      ST_TAKE  = 2'b01,
      ST_BURST = 2'b10
   } usf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_en;
      logic burst_step;
   } usf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
      logic closes;
      logic burst_last;
   } usf_sts_type;

endpackage

// ===== rtl/utf8_sequence_filter_unit.sv =====
// Top level of the UTF-8 sequence filter.
//
// Usage: bytes enter on the req_ stream channel, one byte per transfer;
// req_tuser marks a resync item, which clears any partial sequence and
// produces nothing. The rsp_ channel carries the accepted bytes; rsp_tlast
// marks the final byte produced by one input item.
// An ASCII byte is presented on rsp_ the cycle after its transfer. Lead and
// continuation bytes are held internally; when the last continuation byte is
// taken, the block plays out the whole 2- to 4-byte sequence, one byte per
// cycle while the receiver keeps up, and takes no input meanwhile.
// Throughput: one input item per cycle while the output slot is free, except
// that after an item closing a sequence no input is taken until the whole
// burst has been read through the single output register.
// A registered output slot separates the sides: a new item is taken while a
// result waits, as long as rsp_tready frees the slot in that cycle. When the
// receiver stalls, the output holds and input is held off.
// Reset (synchronous, active high) empties the output and drops any partial
// sequence.
module utf8_sequence_filter_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast
);
   import usf_pkg::*;

   usf_cmd_type cmd;
   usf_sts_type sts;

   usf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   usf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Input is taken only in the take state with a free output slot.
   assign req_tready = cmd.take_en;

endmodule

// ===== rtl/usf_ctrl.sv =====
// Controller state machine: takes items, then plays out finished sequences.
module usf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  usf_pkg::usf_sts_type sts,
   output usf_pkg::usf_cmd_type cmd
);
   import usf_pkg::*;

   usf_state_type state_ff;
   usf_state_type state_in;

   // Commands follow the state; both wait for a free output slot.
   always_comb begin
      cmd.take_en    = (state_ff == ST_TAKE) & sts.slot_free;
      cmd.burst_step = (state_ff == ST_BURST) & sts.slot_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_TAKE: begin
            if (cmd.take_en && req_tvalid && sts.closes) begin
               state_in = ST_BURST;
            end
         end
         ST_BURST: begin
            if (cmd.burst_step && sts.burst_last) begin
               state_in = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A burst is only entered from an accepted byte that closes a sequence.
   a_burst_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST && $past(state_ff) == ST_TAKE)
      |-> $past(cmd.take_en && req_tvalid && sts.closes))
      else $error("burst entered without a closing byte");

endmodule

// ===== rtl/usf_datapath.sv =====
// Datapath: byte classification, held sequence, and output register.
module usf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  usf_pkg::usf_cmd_type cmd,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   input  logic [7:0]           req_tdata,
   input  logic                 rsp_tready,
   output usf_pkg::usf_sts_type sts,
   output logic                 rsp_tvalid,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import usf_pkg::*;

   logic [1:0]           expected_ff, expected_in;
   logic [SEQ_CNT_W-1:0] collected_ff, collected_in;
   logic [SEQ_IDX_W-1:0] emit_idx_ff, emit_idx_in;
   logic [7:0]           seq_ff [SEQ_DEPTH];
   logic [7:0]           seq_in [SEQ_DEPTH];
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_valid_ff, out_valid_in;

   logic                 take_fire;
   logic                 is_cont;
   logic [SEQ_CNT_W-1:0] emit_cnt;

   assign take_fire = cmd.take_en & req_tvalid;
   assign is_cont   = (req_tdata[7:6] == CONT_TAG);
   assign emit_cnt  = {1'b0, emit_idx_ff} + SEQ_CNT_W'(1);

   // Status toward the controller.
   always_comb begin
      sts.slot_free  = ~out_valid_ff | rsp_tready;
      sts.closes     = (req_tuser == KIND_DATA) && (expected_ff == 2'd1) && is_cont;
      sts.burst_last = (emit_cnt == collected_ff);
   end

   // Sequence tracking and output loading.
   always_comb begin
      expected_in  = expected_ff;
      collected_in = collected_ff;
      seq_in       = seq_ff;
      emit_idx_in  = emit_idx_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      if (take_fire) begin
         if (req_tuser == KIND_RESYNC) begin
            expected_in  = 2'd0;
            collected_in = '0;
         end else if (expected_ff == 2'd0) begin
            expected_in  = 2'd0;
            collected_in = '0;
            case (req_tdata) inside
               [ASCII_MIN:ASCII_MAX]: begin
                  out_byte_in  = req_tdata;
                  out_last_in  = 1'b1;
                  out_valid_in = 1'b1;
               end
               [LEAD2_MIN:LEAD2_MAX]: begin
                  expected_in  = 2'd1;
                  collected_in = SEQ_CNT_W'(1);
                  seq_in[0]    = req_tdata;
               end
               [LEAD3_MIN:LEAD3_MAX]: begin
                  expected_in  = 2'd2;
                  collected_in = SEQ_CNT_W'(1);
                  seq_in[0]    = req_tdata;
               end
               [LEAD4_MIN:LEAD4_MAX]: begin
                  expected_in  = 2'd3;
                  collected_in = SEQ_CNT_W'(1);
                  seq_in[0]    = req_tdata;
               end
               default: begin
                  // Stray continuation byte or an invalid lead: dropped.
               end
            endcase
         end else if (!is_cont) begin
            // A break inside a sequence discards it and the byte.
            expected_in  = 2'd0;
            collected_in = '0;
         end else begin
            expected_in = expected_ff - 2'd1;
            if (!collected_ff[SEQ_CNT_W-1]) begin
               seq_in[collected_ff[SEQ_IDX_W-1:0]] = req_tdata;
               collected_in = collected_ff + SEQ_CNT_W'(1);
            end
         end
      end else if (cmd.burst_step) begin
         out_byte_in  = seq_ff[emit_idx_ff];
         out_last_in  = sts.burst_last;
         out_valid_in = 1'b1;
         if (sts.burst_last) begin
            emit_idx_in  = '0;
            collected_in = '0;
         end else begin
            emit_idx_in = emit_idx_ff + SEQ_IDX_W'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= 2'd0;
         collected_ff <= '0;
         emit_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         expected_ff  <= expected_in;
         collected_ff <= collected_in;
         emit_idx_ff  <= emit_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // An open sequence always holds its lead and never outgrows the store.
   a_open_seq: assert property (@(posedge clock) disable iff (reset)
      (expected_ff != 2'd0) |-> (collected_ff != '0)
      && (({1'b0, expected_ff} + collected_ff) <= SEQ_CNT_W'(SEQ_DEPTH)))
      else $error("open sequence count out of range");

   // A burst plays out a closed sequence of at least two bytes.
   a_burst_len: assert property (@(posedge clock) disable iff (reset)
      cmd.burst_step |-> (collected_ff >= SEQ_CNT_W'(2)) && (expected_ff == 2'd0))
      else $error("burst on an unfinished sequence");

   // Taking an item and playing a burst never coincide.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_en && cmd.burst_step))
      else $error("take and burst commands overlap");

endmodule

// ===== verif/utf8_sequence_filter_unit_tb.sv =====
// Self-checking testbench for the UTF-8 sequence filter with random flow control.
module utf8_sequence_filter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usf_pkg::*;

   // Continuation byte range (10xxxxxx) and run limits.
   localparam logic [7:0] CONT_MIN    = 8'h80;
   localparam logic [7:0] CONT_MAX    = 8'hBF;
   localparam int         MAX_WAIT    = 18;
   localparam int         RANDOM_DATA = 70;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         MAX_PRINTS  = 30;

   // One byte expected on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } char_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tuser  = KIND_DATA; // [0] kind
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tlast;            // last_of_run

   // Predicted sequence state, kept in step with accepted input transfers.
   int         cont_missing;
   int         held_count;
   logic [7:0] held_bytes [SEQ_DEPTH];
   char_byte_type expected_bytes [$];

   // Flow-control modes and run statistics.
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int cycle_count   = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int resyncs_sent  = 0;
   int bytes_checked = 0;
   int runs_checked  = 0;

   utf8_sequence_filter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d bytes outstanding.",
                  cycle_count, expected_bytes.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Idle cycles before the next transfer; none while a side runs steady.
   function automatic int draw_wait(bit steady);
      if (steady || $urandom_range(0, 2) != 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Forget any open sequence.
   task automatic drop_sequence();
      cont_missing = 0;
      held_count   = 0;
   endtask

   // Start holding a sequence that needs the given number of continuation bytes.
   task automatic open_sequence(input logic [7:0] lead, input int conts);
      held_bytes[0] = lead;
      held_count    = 1;
      cont_missing  = conts;
   endtask

   // Work out the bytes that one accepted input item releases.
   task automatic predict_item(input logic kind, input logic [7:0] in_byte);
      int i;
      if (kind == KIND_RESYNC) begin
         drop_sequence();
      end else if (cont_missing == 0) begin
         // No sequence open: classify the byte as ASCII, a lead byte, or junk.
         drop_sequence();
         if (in_byte >= LEAD2_MIN && in_byte <= LEAD2_MAX) begin
            open_sequence(in_byte, 1);
         end else if (in_byte >= LEAD3_MIN && in_byte <= LEAD3_MAX) begin
            open_sequence(in_byte, 2);
         end else if (in_byte >= LEAD4_MIN && in_byte <= LEAD4_MAX) begin
            open_sequence(in_byte, 3);
         end else if (in_byte <= ASCII_MAX) begin
            expected_bytes.push_back('{out_byte: in_byte, last_of_run: 1'b1});
         end
      end else if (in_byte[7:6] != CONT_TAG) begin
         // A broken sequence is discarded together with the offending byte.
         drop_sequence();
      end else begin
         held_bytes[held_count] = in_byte;
         held_count++;
         cont_missing--;
         if (cont_missing == 0) begin
            for (i = 0; i < held_count; i++) begin
               expected_bytes.push_back('{out_byte: held_bytes[i],
                                          last_of_run: (i == held_count - 1)});
            end
            drop_sequence();
         end
      end
   endtask

   // Drive one item and wait for its transfer; valid stays high across back-to-back items.
   task automatic send_item(input logic kind, input logic [7:0] in_byte);
      int gap;
      gap = draw_wait(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= in_byte;
      do @(posedge clock); while (!req_tready);
      predict_item(kind, in_byte);
      items_sent++;
      if (kind == KIND_RESYNC) resyncs_sent++;
   endtask

   // Receiver: random stalls, and every result transfer checked against the oldest expectation.
   initial begin
      int stall;
      char_byte_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         bytes_checked++;
         if (rsp_tlast) runs_checked++;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_tdata, want.out_byte));
            if (rsp_tlast !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %0b on byte %02h, expected %0b",
                                         rsp_tlast, rsp_tdata, want.last_of_run));
         end
      end
   end

   // ASCII extremes and one complete character of each length, at full rate.
   task automatic test_valid_characters();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      send_item(KIND_DATA, ASCII_MIN);
      send_item(KIND_DATA, ASCII_MAX);
      send_item(KIND_DATA, LEAD2_MIN);
      send_item(KIND_DATA, CONT_MIN);
      send_item(KIND_DATA, LEAD3_MAX);
      send_item(KIND_DATA, CONT_MAX);
      send_item(KIND_DATA, CONT_MAX);
      send_item(KIND_DATA, LEAD4_MAX);
      send_item(KIND_DATA, CONT_MIN);
      send_item(KIND_DATA, CONT_MAX);
      send_item(KIND_DATA, CONT_MIN);
   endtask

   // Stray continuation, bytes above the 4-byte leads, broken and resynced sequences.
   task automatic test_rejected_bytes();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      send_item(KIND_DATA, CONT_MIN);
      send_item(KIND_DATA, 8'hF8);
      send_item(KIND_DATA, 8'hFF);
      // An ASCII byte inside a sequence is dropped, not passed on.
      send_item(KIND_DATA, LEAD3_MIN);
      send_item(KIND_DATA, 8'h41);
      // A lead byte inside a sequence is dropped too.
      send_item(KIND_DATA, LEAD2_MAX);
      send_item(KIND_DATA, LEAD2_MIN);
      // Resync mid-sequence leaves the next continuation byte stray.
      send_item(KIND_DATA, LEAD4_MIN);
      send_item(KIND_DATA, CONT_MIN);
      send_item(KIND_RESYNC, 8'hFF);
      send_item(KIND_DATA, CONT_MAX);
      send_item(KIND_RESYNC, 8'h00);
      send_item(KIND_DATA, 8'h7E);
   endtask

   // Mostly well-formed characters with random content, plus lone resyncs, truncated sequences and noise.
   task automatic test_random_stream();
      int data_items;
      int pick;
      int len;
      int keep;
      int k;
      logic [7:0] lead;
      logic [7:0] breaker;
      data_items = 0;
      while (data_items < RANDOM_DATA) begin
         if ($urandom_range(0, 15) == 0) req_steady = !req_steady;
         if ($urandom_range(0, 15) == 0) rsp_steady = !rsp_steady;
         pick = $urandom_range(0, 99);
         len  = $urandom_range(1, 4);
         case (len)
            1: lead = 8'($urandom_range(ASCII_MIN, ASCII_MAX));
            2: lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
            3: lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
            default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
         endcase
         if (pick < 70) begin
            // Complete character.
            send_item(KIND_DATA, lead);
            for (k = 1; k < len; k++)
               send_item(KIND_DATA, 8'($urandom_range(CONT_MIN, CONT_MAX)));
            data_items += len;
         end else if (pick < 80) begin
            send_item(KIND_RESYNC, 8'($urandom_range(0, 255)));
         end else if (pick < 90 && len > 1) begin
            // Sequence cut short by a non-continuation byte or by a resync.
            keep = $urandom_range(0, len - 2);
            send_item(KIND_DATA, lead);
            for (k = 0; k < keep; k++)
               send_item(KIND_DATA, 8'($urandom_range(CONT_MIN, CONT_MAX)));
            breaker = 8'($urandom_range(0, 255));
            if (breaker[7:6] == CONT_TAG) breaker[6] = 1'b1;
            if ($urandom_range(0, 1) == 0) begin
               send_item(KIND_DATA, breaker);
               data_items += keep + 2;
            end else begin
               send_item(KIND_RESYNC, breaker);
               data_items += keep + 1;
            end
         end else begin
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
            data_items++;
         end
      end
   endtask

   // Test sequence and final verdict.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      drop_sequence();
      @(posedge clock);

      test_valid_characters();
      test_rejected_bytes();
      test_random_stream();
      req_tvalid <= 1'b0;

      // Let every predicted byte arrive, then watch for stray extra output.
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d resyncs) with random gaps and stalls.",
               items_sent, resyncs_sent);
      $display("Checked %0d output bytes closing %0d runs; %0d mismatches.",
               bytes_checked, runs_checked, error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
